@@ design/chacha20_stream_xor_unit_defines.svh @@
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR unit - assertion macros
// Clocked property checks; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_XOR_UNIT_DEFINES_SVH
`define CHACHA20_STREAM_XOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge outside reset.
`define CC20S_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that cond never holds at a rising edge outside reset.
`define CC20S_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CC20S_ASSERT(lbl, clk, rst_n, prop, msg)
`define CC20S_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ design/cc20s_pkg.sv @@
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR package
// Shared widths, constants, register indexes and types.
// ----------------------------------------------------------------------------
package cc20s_pkg;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned DR_W          = $clog2(DOUBLE_ROUNDS + 1);

  localparam int unsigned WORDS       = 16;
  localparam int unsigned WORD_IDX_W  = 4;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_01   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_23   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_45   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_67   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_2  = 3'd5;

  typedef logic [31:0] word_t;

  // Rotate amount of the shared mixing step, one per quarter-round step.
  typedef enum logic [1:0] {
    ROT_16,
    ROT_12,
    ROT_8,
    ROT_7
  } rot_sel_t;

endpackage

@@ design/chacha20_stream_xor_unit.sv @@
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR unit
// Combines each data byte with the next byte of a ChaCha20 keystream.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write key and nonce registers (index 0..5) while the unit is idle;
//            cfg_ready is always high, indexes 6 and 7 are ignored.
//   in_*   : one request per byte; in_call_start drops unused keystream, and
//            in_restart also zeroes the block counter and loads nonce word 0
//            from register 4 before the block is made.
//   out_*  : one result byte per request, in order.
// Sequence:
//   A byte taken from the current keystream block passes through the emit
//   state into the result register; the next request is taken once the
//   unit is back in idle.
//   A byte that needs a new block first goes through a load step, the
//   quarter-round steps of all DOUBLE_ROUNDS double rounds, and a
//   feed-forward add for each word, then the emit state. One shared
//   add/xor/rotate unit does every step, one quarter-round line each.
// Reset: key and nonce registers zero, block counter and nonce word 0
//   zero, keystream empty, so the first byte always makes a block.
// Stall: the output register holds a result while out_ready is low; one more
//   request is taken and waits in the emit state until the register frees.
// ----------------------------------------------------------------------------
`include "chacha20_stream_xor_unit_defines.svh"

module chacha20_stream_xor_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cc20s_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cc20s_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_call_start,
  input  logic                                 in_restart,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_byte
);
  import cc20s_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FINAL,
    S_EMIT
  } state_t;

  localparam logic [DR_W-1:0]       DR_LAST  = DR_W'(DOUBLE_ROUNDS - 1);
  localparam logic [WORD_IDX_W-1:0] FIN_LAST = WORD_IDX_W'(WORDS - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] key_r [4];
  logic [CFG_DATA_W-1:0] nonce01_r;
  word_t                 nonce2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
      nonce01_r <= '0;
      nonce2_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_01:   key_r[0]  <= cfg_data;
        REG_KEY_23:   key_r[1]  <= cfg_data;
        REG_KEY_45:   key_r[2]  <= cfg_data;
        REG_KEY_67:   key_r[3]  <= cfg_data;
        REG_NONCE_01: nonce01_r <= cfg_data;
        REG_NONCE_2:  nonce2_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Block state, sequencer and result register
  // --------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  word_t                 w_r [WORDS];
  word_t                 w_nxt [WORDS];
  word_t                 tmp_w [WORDS];
  word_t                 init_w [WORDS];
  word_t                 counter_r, counter_nxt;
  word_t                 carry_r, carry_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [1:0]            step_r, step_nxt;
  logic [1:0]            quarter_r, quarter_nxt;
  logic                  diag_r, diag_nxt;
  logic [DR_W-1:0]       dround_r, dround_nxt;
  logic [WORD_IDX_W-1:0] fin_r, fin_nxt;
  logic [7:0]            data_r, data_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;

  word_t                 unit_x, unit_y, unit_z;
  rot_sel_t              unit_rot;
  word_t                 unit_sum, unit_mix;
  word_t                 ks_word;
  logic [7:0]            ks_byte;
  logic                  out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_free  = !out_valid_r || out_ready;

  // Initial block state: constants, key, counter and nonce words.
  always_comb begin
    init_w[0]  = SIGMA_0;
    init_w[1]  = SIGMA_1;
    init_w[2]  = SIGMA_2;
    init_w[3]  = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_r[i][31:0];
      init_w[5 + 2 * i] = key_r[i][63:32];
    end
    init_w[12] = counter_r;
    init_w[13] = carry_r;
    init_w[14] = nonce01_r[63:32];
    init_w[15] = nonce2_r;
  end

  // Row shift after each quarter round. The active quarter always sits in
  // column 0; the last quarter of a column pass also diagonalizes the rows
  // and the last quarter of a diagonal pass restores them.
  function automatic logic [1:0] row_shift(logic [1:0] row, logic [1:0] quarter,
                                           logic diag);
    logic [1:0] amt;
    if (quarter != 2'd3) begin
      amt = 2'd1;
    end else if (!diag) begin
      amt = 2'(row + 2'd1);
    end else begin
      amt = 2'(2'd1 - row);
    end
    return amt;
  endfunction

  // Operand selection for the shared unit.
  always_comb begin
    if (state_r == S_FINAL) begin
      unit_x = w_r[0];
      unit_y = init_w[fin_r];
      unit_z = w_r[0];
    end else if (!step_r[0]) begin
      unit_x = w_r[0];
      unit_y = w_r[4];
      unit_z = w_r[12];
    end else begin
      unit_x = w_r[8];
      unit_y = w_r[12];
      unit_z = w_r[4];
    end
    case (step_r)
      2'd0:    unit_rot = ROT_16;
      2'd1:    unit_rot = ROT_12;
      2'd2:    unit_rot = ROT_8;
      default: unit_rot = ROT_7;
    endcase
  end

  cc20s_qr_unit u_qr (
    .x_i   (unit_x),
    .y_i   (unit_y),
    .z_i   (unit_z),
    .rot_i (unit_rot),
    .sum_o (unit_sum),
    .mix_o (unit_mix)
  );

  // Keystream byte at the current position, little-endian within the word.
  assign ks_word = w_r[pos_r[5:2]];
  assign ks_byte = ks_word[{pos_r[1:0], 3'b000} +: 8];

  // Working state update for one step.
  always_comb begin
    for (int i = 0; i < WORDS; i++) begin
      tmp_w[i] = w_r[i];
      w_nxt[i] = w_r[i];
    end
    if (!step_r[0]) begin
      tmp_w[0]  = unit_sum;
      tmp_w[12] = unit_mix;
    end else begin
      tmp_w[8]  = unit_sum;
      tmp_w[4]  = unit_mix;
    end
    unique case (state_r)
      S_LOAD: begin
        for (int i = 0; i < WORDS; i++) begin
          w_nxt[i] = init_w[i];
        end
      end
      S_ROUND: begin
        if (step_r == 2'd3) begin
          for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
              w_nxt[4 * r + j] =
                tmp_w[{2'(r), 2'(2'(j) + row_shift(2'(r), quarter_r, diag_r))}];
            end
          end
        end else begin
          for (int i = 0; i < WORDS; i++) begin
            w_nxt[i] = tmp_w[i];
          end
        end
      end
      S_FINAL: begin
        // Shift the words down and append the feed-forward sum at the top.
        for (int i = 0; i < WORDS - 1; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[WORDS-1] = unit_sum;
      end
      default: ;
    endcase
  end

  // Sequencer and result register.
  always_comb begin
    state_nxt     = state_r;
    counter_nxt   = counter_r;
    carry_nxt     = carry_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    quarter_nxt   = quarter_r;
    diag_nxt      = diag_r;
    dround_nxt    = dround_r;
    fin_nxt       = fin_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          data_nxt = in_data_byte;
          if (in_restart) begin
            counter_nxt = '0;
            carry_nxt   = nonce01_r[31:0];
          end
          // Drop unused keystream on a call start or restart.
          if (in_restart || in_call_start || pos_r[6]) begin
            pos_nxt   = POS_W'(64);
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_LOAD: begin
        step_nxt    = '0;
        quarter_nxt = '0;
        diag_nxt    = 1'b0;
        dround_nxt  = '0;
        fin_nxt     = '0;
        state_nxt   = S_ROUND;
      end
      S_ROUND: begin
        step_nxt = 2'(step_r + 2'd1);
        if (step_r == 2'd3) begin
          quarter_nxt = 2'(quarter_r + 2'd1);
          if (quarter_r == 2'd3) begin
            diag_nxt = !diag_r;
            if (diag_r) begin
              dround_nxt = DR_W'(dround_r + 1'b1);
              if (dround_r == DR_LAST) begin
                state_nxt = S_FINAL;
              end
            end
          end
        end
      end
      S_FINAL: begin
        fin_nxt = WORD_IDX_W'(fin_r + 1'b1);
        if (fin_r == FIN_LAST) begin
          // Advance the block counter; carry into nonce word 0 on wrap.
          counter_nxt = counter_r + 32'd1;
          if (counter_r == '1) begin
            carry_nxt = carry_r + 32'd1;
          end
          pos_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_byte_nxt  = data_r ^ ks_byte;
          out_valid_nxt = 1'b1;
          pos_nxt       = POS_W'(pos_r + 1'b1);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      counter_r   <= '0;
      carry_r     <= '0;
      pos_r       <= POS_W'(64);
      step_r      <= '0;
      quarter_r   <= '0;
      diag_r      <= 1'b0;
      dround_r    <= '0;
      fin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      counter_r   <= counter_nxt;
      carry_r     <= carry_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      quarter_r   <= quarter_nxt;
      diag_r      <= diag_nxt;
      dround_r    <= dround_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    for (int i = 0; i < WORDS; i++) begin
      w_r[i] <= w_nxt[i];
    end
    data_r     <= data_nxt;
    out_byte_r <= out_byte_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CC20S_NEVER(a_emit_has_keystream, clk, rst_n, (state_r == S_EMIT) && pos_r[6], "emit with exhausted keystream")
  `CC20S_ASSERT(a_block_end_pos, clk, rst_n, (state_r == S_FINAL) && (fin_r == FIN_LAST) |=> (pos_r == '0) && (state_r == S_EMIT), "block end did not rewind position")
  `CC20S_ASSERT(a_block_end_count, clk, rst_n, (state_r == S_FINAL) && (fin_r == FIN_LAST) |=> counter_r == $past(counter_r) + 32'd1, "block counter not advanced")
  `CC20S_ASSERT(a_restart_load, clk, rst_n, (state_r == S_IDLE) && in_valid && in_restart |=> (counter_r == '0) && (state_r == S_LOAD), "restart did not clear counter")

endmodule

@@ design/cc20s_qr_unit.sv @@
// ----------------------------------------------------------------------------
// ChaCha20 shared mixing step
// One add, xor and fixed rotate: sum = x + y, mix = rotl(z ^ sum, n).
// ----------------------------------------------------------------------------
module cc20s_qr_unit (
  input  cc20s_pkg::word_t    x_i,
  input  cc20s_pkg::word_t    y_i,
  input  cc20s_pkg::word_t    z_i,
  input  cc20s_pkg::rot_sel_t rot_i,
  output cc20s_pkg::word_t    sum_o,
  output cc20s_pkg::word_t    mix_o
);
  import cc20s_pkg::*;

  word_t sum;
  word_t mixed;

  assign sum   = x_i + y_i;
  assign mixed = z_i ^ sum;
  assign sum_o = sum;

  always_comb begin
    unique case (rot_i)
      ROT_16: mix_o = {mixed[15:0], mixed[31:16]};
      ROT_12: mix_o = {mixed[19:0], mixed[31:20]};
      ROT_8:  mix_o = {mixed[23:0], mixed[31:24]};
      ROT_7:  mix_o = {mixed[24:0], mixed[31:25]};
    endcase
  end

endmodule

@@ tb/sv/tb_chacha20_stream_xor_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR unit testbench
// Sends byte requests and key/nonce register writes, rebuilds the keystream
// inside the bench to work out each result byte, and checks every result in
// order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_xor_unit;
  import cc20s_pkg::*;

  // Register indexes the unit decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam int unsigned STREAM_PHASES     = 6;
  localparam int unsigned BYTES_PER_PHASE   = 268;
  localparam int unsigned BACKPRESSURE_REQS = 20;
  // Longer than one block build, so the unit fills up and drops in_ready.
  localparam int unsigned HOLD_OFF_CYCLES   = 1000;
  localparam int unsigned DRAIN_CYCLES      = 400;
  localparam int unsigned RUN_LIMIT_NS      = 6_000_000;
  localparam int unsigned REPORT_LIMIT      = 100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_data_byte;
  logic                  in_call_start;
  logic                  in_restart;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;

  // Bench copy of the unit state.
  logic [CFG_DATA_W-1:0] reg_file [6];
  word_t                 block_ctr;
  word_t                 nonce0_run;
  word_t                 keystream_words [WORDS];
  logic [POS_W-1:0]      ks_pos;
  word_t                 mix_w [WORDS];

  logic [7:0]            expected_xor_bytes [$];
  int unsigned           error_count;
  int unsigned           gap_max;
  int unsigned           stall_max;
  bit                    hold_req;

  chacha20_stream_xor_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_call_start(in_call_start),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Keystream prediction
  // --------------------------------------------------------------------------
  function automatic word_t rotl32(input word_t v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // One quarter round on the working words.
  function automatic void quarter_round(input int a, input int b, input int c, input int d);
    mix_w[a] = mix_w[a] + mix_w[b];
    mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d];
    mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b];
    mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d];
    mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 7);
  endfunction

  // Build the next 64-byte keystream block from the registers as they are now,
  // then advance the counter and carry its wrap into nonce word 0.
  function automatic void build_keystream_block();
    word_t init_w [WORDS];
    int    i;
    int    r;
    init_w[0] = SIGMA_0;
    init_w[1] = SIGMA_1;
    init_w[2] = SIGMA_2;
    init_w[3] = SIGMA_3;
    for (i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = reg_file[i][31:0];
      init_w[5 + 2 * i] = reg_file[i][63:32];
    end
    init_w[12] = block_ctr;
    init_w[13] = nonce0_run;
    init_w[14] = reg_file[REG_NONCE_01][63:32];
    init_w[15] = reg_file[REG_NONCE_2][31:0];
    for (i = 0; i < WORDS; i++) begin
      mix_w[i] = init_w[i];
    end
    for (r = 0; r < DOUBLE_ROUNDS; r++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    for (i = 0; i < WORDS; i++) begin
      keystream_words[i] = mix_w[i] + init_w[i];
    end
    block_ctr = block_ctr + 32'd1;
    if (block_ctr == '0) begin
      nonce0_run = nonce0_run + 32'd1;
    end
  endfunction

  // Work out the result byte of one accepted request and advance the state.
  function automatic logic [7:0] predict_xor_byte(input logic [7:0] data, input logic cs,
                                                  input logic rs);
    word_t      ks_word;
    logic [7:0] ks_byte;
    if (rs) begin
      block_ctr  = '0;
      nonce0_run = reg_file[REG_NONCE_01][31:0];
      ks_pos     = 7'd64;
    end
    if (cs) begin
      ks_pos = 7'd64;
    end
    if (ks_pos >= 7'd64) begin
      build_keystream_block();
      ks_pos = '0;
    end
    ks_word = keystream_words[ks_pos[5:2]];
    ks_byte = ks_word[8 * ks_pos[1:0] +: 8];
    ks_pos  = ks_pos + 7'd1;
    return data ^ ks_byte;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: drive out_ready with random stalls and honor a long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        // Hold the result channel closed so requests pile up behind it.
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff (out_valid || hold_req));
    end
  end

  // Compare every accepted result with the oldest waiting expectation.
  always @(posedge clk) begin : result_checker
    logic [7:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_xor_bytes.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t ns: result with nothing expected, expected none, actual 8'h%02h",
                   $time, out_byte);
        end
      end else begin
        want = expected_xor_bytes.pop_front();
        if (out_byte !== want) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t ns: out_byte mismatch, expected 8'h%02h, actual 8'h%02h",
                     $time, want, out_byte);
          end
        end
      end
      if (error_count == REPORT_LIMIT + 1) begin
        $display("%0t ns: further mismatch reports suppressed", $time);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------
  // Offer one byte request after a random gap; keep valid high on a zero gap
  // so back-to-back requests never lower and raise it in the same step.
  task automatic send_byte(input logic [7:0] data, input logic cs, input logic rs);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= data;
    in_call_start <= cs;
    in_restart    <= rs;
    do @(posedge clk); while (!in_ready);
    expected_xor_bytes.push_back(predict_xor_byte(data, cs, rs));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx) inside
      REG_KEY_01, REG_KEY_23, REG_KEY_45, REG_KEY_67, REG_NONCE_01: reg_file[idx] = val;
      REG_NONCE_2: reg_file[idx] = {32'h0, val[31:0]};
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_key_and_nonce(input logic [63:0] k01, input logic [63:0] k23,
                                     input logic [63:0] k45, input logic [63:0] k67,
                                     input logic [63:0] n01, input logic [63:0] n2);
    write_reg(REG_KEY_01, k01);
    write_reg(REG_KEY_23, k23);
    write_reg(REG_KEY_45, k45);
    write_reg(REG_KEY_67, k67);
    write_reg(REG_NONCE_01, n01);
    write_reg(REG_NONCE_2, n2);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_xor_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Nonce word 0 stays zero after reset until a restart loads register 4.
  task automatic test_nonce_zero_after_reset();
    gap_max   = 0;
    stall_max = 0;
    write_key_and_nonce(rand64(), rand64(), rand64(), rand64(), rand64() | 64'h1, rand64());
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  // Call start alone, restart alone, and both together.
  task automatic test_call_and_restart_flags();
    gap_max   = 2;
    stall_max = 2;
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h0F, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hF0, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b1, 1'b1);
    send_byte(8'hC3, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b1, 1'b0);
    send_byte(8'h81, 1'b0, 1'b1);
  endtask

  // All-ones and all-zero registers, then writes to unmapped indexes.
  task automatic test_register_extremes();
    wait_idle();
    write_key_and_nonce('1, '1, '1, '1, '1, '1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    wait_idle();
    write_key_and_nonce('0, '0, '0, '0, '0, '0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_UNMAPPED_LO, '1);
    write_reg(REG_UNMAPPED_HI, rand64());
    send_byte(8'h77, 1'b0, 1'b1);
    send_byte(8'h88, 1'b0, 1'b0);
  endtask

  // Close the result channel for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    int i;
    wait_idle();
    gap_max   = 0;
    stall_max = 0;
    hold_req  = 1'b1;
    for (i = 0; i < BACKPRESSURE_REQS; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 0, 1'b0);
    end
    wait_idle();
  endtask

  // Calls of random length with random content; a few long calls run past
  // the end of a keystream block, and stray flags add noise inside calls.
  task automatic test_random_streams();
    int unsigned phase;
    int unsigned sent;
    int unsigned call_len;
    int unsigned j;
    logic        cs;
    logic        rs;
    int unsigned pace [3];
    pace[0] = 0;
    pace[1] = 3;
    pace[2] = 12;
    for (phase = 0; phase < STREAM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: write_key_and_nonce('0, '0, '0, '0, '0, '0);
        1: write_key_and_nonce('1, '1, '1, '1, '1, '1);
        default: write_key_and_nonce(rand64(), rand64(), rand64(), rand64(),
                                     rand64(), rand64());
      endcase
      gap_max   = pace[$urandom_range(0, 2)];
      stall_max = pace[$urandom_range(0, 2)];
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        call_len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 40);
        for (j = 0; j < call_len && sent < BYTES_PER_PHASE; j++) begin
          if (j == 0) begin
            case ($urandom_range(0, 7))
              0: begin
                cs = 1'b0;
                rs = 1'b1;
              end
              1: begin
                cs = 1'b1;
                rs = 1'b1;
              end
              default: begin
                cs = 1'b1;
                rs = 1'b0;
              end
            endcase
          end else begin
            cs = ($urandom_range(0, 39) == 0);
            rs = ($urandom_range(0, 59) == 0);
          end
          send_byte(8'($urandom_range(0, 255)), cs, rs);
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // Start the bench state from reset values.
    for (int i = 0; i < 6; i++) begin
      reg_file[i] = '0;
    end
    for (int i = 0; i < WORDS; i++) begin
      keystream_words[i] = '0;
    end
    block_ctr     = '0;
    nonce0_run    = '0;
    ks_pos        = 7'd64;
    error_count   = 0;
    gap_max       = 0;
    stall_max     = 4;
    hold_req      = 1'b0;
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_data_byte  <= '0;
    in_call_start <= 1'b0;
    in_restart    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_nonce_zero_after_reset();
    test_call_and_restart_flags();
    test_register_extremes();
    test_output_backpressure();
    test_random_streams();

    // Drain, then give stray results time to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake or lost results.
  initial begin
    #(RUN_LIMIT_NS);
    $display("%0t ns: timeout, %0d results still expected", $time, expected_xor_bytes.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
